@@ rtl/matrix_multiply_assert.svh @@
// Assertion macros used by the checker of this block.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication.
`define MM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("matrix_multiply check failed");

// Next-cycle implication.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("matrix_multiply check failed");

`endif

@@ rtl/mm_pkg.sv @@
package mm_pkg;

	localparam int DIM_W = 5;
	localparam int IDX_W = 4;
	localparam int VAL_W = 32;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W = PROD_W + DIM_W;
	localparam int OUT_COLS_MAX = 16;
	localparam int CMD_W = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd2;

	// one issued MAC step
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic col_end;
		logic [IDX_W-1:0] col;
	} mm_tag_t;

	// one finished dot product
	typedef struct packed {
		logic valid;
		logic col_end;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} mm_res_t;

	typedef struct packed {
		logic stall;
		logic busy;
	} mm_pipe_t;

endpackage

@@ rtl/mm_ram.sv @@
module mm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

@@ rtl/mm_ctrl.sv @@
module mm_ctrl #(
	parameter int MAX_DIM = 16,
	localparam int AW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [mm_pkg::CMD_W-1:0]     cmd,
	input  logic [mm_pkg::IDX_W-1:0]     row,
	input  logic [mm_pkg::IDX_W-1:0]     col,
	input  logic [mm_pkg::DIM_W-1:0]     rows_a,
	input  logic [mm_pkg::DIM_W-1:0]     inner_dim,
	input  logic [mm_pkg::DIM_W-1:0]     cols_b,
	input  mm_pkg::mm_pipe_t             pst,
	input  logic                         out_free,
	output logic                         err_load,
	output logic [mm_pkg::IDX_W-1:0]     cur_row,
	output logic                         a_en,
	output logic                         b_en,
	output logic                         mem_we,
	output logic [AW-1:0]                a_addr,
	output logic [AW-1:0]                b_addr,
	output mm_pkg::mm_tag_t              tag
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ERR = 2'd3;

	logic [1:0] state_q;
	logic [mm_pkg::IDX_W-1:0] row_q;
	logic [mm_pkg::DIM_W-1:0] k_q;
	logic [mm_pkg::IDX_W-1:0] j_q;
	logic acc_in;
	logic in_range;
	logic run_go;
	logic k_last;
	logic j_last;
	logic [AW-1:0] wr_addr;

	assign in_ready = (state_q == ST_IDLE);
	assign acc_in = in_valid & in_ready;
	assign in_range = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign run_go = (state_q == ST_RUN) & ~pst.stall;
	assign k_last = (k_q == inner_dim - 5'd1);
	assign j_last = ({1'b0, j_q} == cols_b - 5'd1);
	assign wr_addr = AW'(int'(row) * MAX_DIM + int'(col));

	assign mem_we = (state_q == ST_IDLE);
	assign a_en = (acc_in & (cmd == mm_pkg::CMD_WR_A) & in_range) | run_go;
	assign b_en = (acc_in & (cmd == mm_pkg::CMD_WR_B) & in_range) | run_go;
	assign a_addr = mem_we ? wr_addr : AW'(int'(row_q) * MAX_DIM + int'(k_q));
	assign b_addr = mem_we ? wr_addr : AW'(int'(k_q) * MAX_DIM + int'(j_q));

	assign tag.valid = (state_q == ST_RUN);
	assign tag.first = (k_q == '0);
	assign tag.last = k_last;
	assign tag.col_end = j_last;
	assign tag.col = j_q;

	assign err_load = (state_q == ST_ERR) & out_free;
	assign cur_row = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			k_q <= '0;
			j_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc_in && cmd == mm_pkg::CMD_COMPUTE) begin
						row_q <= row;
						k_q <= '0;
						j_q <= '0;
						if ({1'b0, row} >= rows_a) begin
							state_q <= ST_ERR;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					if (!pst.stall) begin
						if (k_last) begin
							k_q <= '0;
							if (j_last) begin
								state_q <= ST_DRAIN;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (!pst.busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/mm_mac.sv @@
module mm_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [mm_pkg::VAL_W-1:0]   a_rdata,
	input  logic [mm_pkg::VAL_W-1:0]   b_rdata,
	input  mm_pkg::mm_tag_t            tag,
	input  logic                       out_free,
	output mm_pkg::mm_res_t            res,
	output mm_pkg::mm_pipe_t           pst
);

	localparam int HI_W = mm_pkg::ACC_W - mm_pkg::VAL_W + 1;

	mm_pkg::mm_tag_t tag_s1;
	mm_pkg::mm_tag_t tag_s2;
	logic signed [mm_pkg::PROD_W-1:0] prod_s2;
	logic signed [mm_pkg::ACC_W-1:0] acc_q;
	logic signed [mm_pkg::VAL_W-1:0] a_op;
	logic signed [mm_pkg::VAL_W-1:0] b_op;
	logic signed [mm_pkg::PROD_W-1:0] prod;
	logic signed [mm_pkg::ACC_W-1:0] prod_ext;
	logic signed [mm_pkg::ACC_W-1:0] sum;
	logic signed [mm_pkg::ACC_W-1:0] shifted;
	logic [HI_W-1:0] hi;
	logic stall;

	assign a_op = a_rdata;
	assign b_op = b_rdata;
	assign prod = a_op * b_op;

	assign stall = tag_s2.valid & tag_s2.last & ~out_free;
	assign pst.stall = stall;
	assign pst.busy = tag_s1.valid | tag_s2.valid;

	assign prod_ext = {{mm_pkg::DIM_W{prod_s2[mm_pkg::PROD_W-1]}}, prod_s2};
	assign sum = (tag_s2.first ? '0 : acc_q) + prod_ext;
	assign shifted = sum >>> FRAC_BITS;
	assign hi = shifted[mm_pkg::ACC_W-1:mm_pkg::VAL_W-1];

	always_comb begin
		res.valid = tag_s2.valid & tag_s2.last & ~stall;
		res.col_end = tag_s2.col_end;
		res.col = tag_s2.col;
		if ((&hi) || !(|hi)) begin
			res.value = shifted[mm_pkg::VAL_W-1:0];
		end else if (hi[HI_W-1]) begin
			res.value = {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
		end else begin
			res.value = {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else if (!stall) begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			prod_s2 <= prod;
		end
		if (tag_s2.valid && !stall) begin
			acc_q <= sum;
		end
	end

endmodule

@@ rtl/matrix_multiply.sv @@
// channel | dir | tdata / data                                   | tuser / index | tlast
// s_      | in  | row_index[3:0] col_index[7:4] element_value[39:8]| cmd[1:0]      | -
// m_      | out | out_row[3:0] out_col[7:4] product_value[39:8]    | error[0]      | last
// cfg_    | in  | register value[4:0]                              | index[1:0]    | -
// A row request is served by the single multiply-accumulate unit, fed by one read of each
// store per cycle while the pipeline is not stalled. An out-of-range row answers with one
// error beat. Reset clears control and sets all three size registers to 1; the stores are
// not cleared. m_tready low while a column result is due freezes the MAC pipeline until
// the output register frees.
module matrix_multiply #(
	parameter int MAX_DIM = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [39:0]                     s_tdata,   // row_index, col_index, element_value
	input  logic [mm_pkg::CMD_W-1:0]        s_tuser,   // cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [39:0]                     m_tdata,   // out_row, out_col, product_value
	output logic                            m_tlast,
	output logic [0:0]                      m_tuser,   // error
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mm_pkg::DIM_W-1:0]        cfg_data
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COL_BOUND = (MAX_DIM < mm_pkg::OUT_COLS_MAX) ? MAX_DIM : mm_pkg::OUT_COLS_MAX;

	function automatic logic [mm_pkg::DIM_W-1:0] clamp_dim(
		input logic [mm_pkg::DIM_W-1:0] v,
		input int bound
	);
		logic [mm_pkg::DIM_W-1:0] r;
		if (v == '0) begin
			r = mm_pkg::DIM_W'(1);
		end else if (int'(v) > bound) begin
			r = mm_pkg::DIM_W'(bound);
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [mm_pkg::DIM_W-1:0] rows_a_q;
	logic [mm_pkg::DIM_W-1:0] inner_dim_q;
	logic [mm_pkg::DIM_W-1:0] cols_b_q;

	logic [mm_pkg::IDX_W-1:0] in_row;
	logic [mm_pkg::IDX_W-1:0] in_col;
	logic [mm_pkg::VAL_W-1:0] in_value;

	logic out_v_q;
	logic [mm_pkg::IDX_W-1:0] out_row_q;
	logic [mm_pkg::IDX_W-1:0] out_col_q;
	logic [mm_pkg::VAL_W-1:0] out_val_q;
	logic out_last_q;
	logic out_err_q;
	logic out_free;

	logic err_load;
	logic [mm_pkg::IDX_W-1:0] cur_row;
	logic a_en;
	logic b_en;
	logic mem_we;
	logic [AW-1:0] a_addr;
	logic [AW-1:0] b_addr;
	logic [mm_pkg::VAL_W-1:0] a_rdata;
	logic [mm_pkg::VAL_W-1:0] b_rdata;
	mm_pkg::mm_tag_t tag;
	mm_pkg::mm_res_t res;
	mm_pkg::mm_pipe_t pst;

	assign in_row = s_tdata[3:0];
	assign in_col = s_tdata[7:4];
	assign in_value = s_tdata[39:8];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= mm_pkg::DIM_W'(1);
			inner_dim_q <= mm_pkg::DIM_W'(1);
			cols_b_q <= mm_pkg::DIM_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mm_pkg::REG_ROWS_A: rows_a_q <= clamp_dim(cfg_data, MAX_DIM);
				mm_pkg::REG_INNER_DIM: inner_dim_q <= clamp_dim(cfg_data, MAX_DIM);
				mm_pkg::REG_COLS_B: cols_b_q <= clamp_dim(cfg_data, COL_BOUND);
				default: ;
			endcase
		end
	end

	mm_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.cmd(s_tuser),
		.row(in_row),
		.col(in_col),
		.rows_a(rows_a_q),
		.inner_dim(inner_dim_q),
		.cols_b(cols_b_q),
		.pst(pst),
		.out_free(out_free),
		.err_load(err_load),
		.cur_row(cur_row),
		.a_en(a_en),
		.b_en(b_en),
		.mem_we(mem_we),
		.a_addr(a_addr),
		.b_addr(b_addr),
		.tag(tag)
	);

	mm_ram #(
		.WIDTH(mm_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_a_ram (
		.clk(clk),
		.en(a_en),
		.we(mem_we),
		.addr(a_addr),
		.wdata(in_value),
		.rdata(a_rdata)
	);

	mm_ram #(
		.WIDTH(mm_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_b_ram (
		.clk(clk),
		.en(b_en),
		.we(mem_we),
		.addr(b_addr),
		.wdata(in_value),
		.rdata(b_rdata)
	);

	mm_mac #(
		.FRAC_BITS(FRAC_BITS)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.a_rdata(a_rdata),
		.b_rdata(b_rdata),
		.tag(tag),
		.out_free(out_free),
		.res(res),
		.pst(pst)
	);

	assign out_free = ~out_v_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res.valid || err_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_row_q <= cur_row;
			out_col_q <= res.col;
			out_val_q <= res.value;
			out_last_q <= res.col_end;
			out_err_q <= 1'b0;
		end else if (err_load) begin
			out_row_q <= cur_row;
			out_col_q <= '0;
			out_val_q <= '0;
			out_last_q <= 1'b1;
			out_err_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {out_val_q, out_col_q, out_row_q};
	assign m_tlast = out_last_q;
	assign m_tuser = out_err_q;

endmodule

@@ rtl/mm_chk.sv @@
`include "matrix_multiply_assert.svh"

module mm_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [mm_pkg::CMD_W-1:0]     s_tuser,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [39:0]                  m_tdata,
	input logic                         m_tlast,
	input logic [0:0]                   m_tuser
);

	logic wr_txn;
	logic cmp_txn;

	assign wr_txn = s_tvalid && s_tready &&
		(s_tuser == mm_pkg::CMD_WR_A || s_tuser == mm_pkg::CMD_WR_B);
	assign cmp_txn = s_tvalid && s_tready && (s_tuser == mm_pkg::CMD_COMPUTE);

	`MM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`MM_ASSERT_NOW(a_err_shape, clk, arst_n, m_tvalid && m_tuser[0], m_tlast && m_tdata[39:4] == 36'd0)
	`MM_ASSERT_NEXT(a_write_stays_idle, clk, arst_n, wr_txn, s_tready)
	`MM_ASSERT_NEXT(a_compute_busy, clk, arst_n, cmp_txn, !s_tready)

endmodule

bind matrix_multiply mm_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tlast(m_tlast),
	.m_tuser(m_tuser)
);
